// ===== hdl/dprq_pkg.sv =====
// shared types, widths and codes for the delayed packet release queue
package dprq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TIME_BITS   = 48;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W       = 32;

    localparam int HANDLE_W    = 16;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int DELAY_W     = 32;
    localparam int NOW_W       = 48;
    localparam int PEND_W      = 6;
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 3;

    localparam int SUM_W       = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;

    // entry layout in the slot memory, lowest bits first
    localparam int OFS_HANDLE  = 0;
    localparam int OFS_IP      = OFS_HANDLE + HANDLE_W;
    localparam int OFS_PORT    = OFS_IP + IP_W;
    localparam int OFS_SEQ     = OFS_PORT + PORT_W;
    localparam int OFS_REL     = OFS_SEQ + SEQ_W;
    localparam int ENTRY_W     = OFS_REL + TIME_BITS;

    localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [HANDLE_W-1:0]  handle;
        logic [IP_W-1:0]      ip;
        logic [PORT_W-1:0]    port;
        logic                 drop;
        logic                 dup;
        logic                 zero_delay;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] release_time;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [IP_W-1:0]     ip;
        logic [PORT_W-1:0]   port;
        logic                last;
        logic [PEND_W-1:0]   pending;
    } res_t;

endpackage

// ===== hdl/dprq_ram.sv =====
// generic single write port ram with registered read
module dprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dprq_cmp.sv =====
// shared key compare unit: ready test and key order against the current best
module dprq_cmp
    import dprq_pkg::*;
(
    input  logic [TIME_BITS-1:0] cand_release,
    input  logic [SEQ_W-1:0]     cand_seq,
    input  logic [TIME_BITS-1:0] best_release,
    input  logic [SEQ_W-1:0]     best_age,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [SEQ_W-1:0]     seq_ctr,
    output logic                 ready,
    output logic                 precedes,
    output logic [SEQ_W-1:0]     cand_age
);

    // age against the running counter keeps insertion order across wrap
    assign cand_age = seq_ctr - cand_seq;
    assign ready    = (cand_release <= now_time);

    always_comb
    begin
        if (cand_release != best_release)
        begin
            precedes = (cand_release < best_release);
        end
        else
        begin
            precedes = (cand_age > best_age);
        end
    end

endmodule

// ===== hdl/dprq_seq.sv =====
// sequencer: command decode, slot insert, ready count and best search passes
module dprq_seq
    import dprq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  req_t               req,
    output logic               in_ready,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_COUNT  = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [SEQ_W-1:0]       seq_ctr_reg, seq_ctr_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       released_reg, released_next;
    logic [ADDR_W:0]        scan_reg, scan_next;
    logic                   rd_live_reg, rd_live_next;
    logic [ADDR_W-1:0]      rd_slot_reg, rd_slot_next;
    logic                   best_found_reg, best_found_next;
    logic                   dup_left_reg, dup_left_next;
    logic                   out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]      best_slot_reg, best_slot_next;
    logic [TIME_BITS-1:0]   best_release_reg, best_release_next;
    logic [SEQ_W-1:0]       best_age_reg, best_age_next;
    logic [HANDLE_W-1:0]    best_handle_reg, best_handle_next;
    logic [IP_W-1:0]        best_ip_reg, best_ip_next;
    logic [PORT_W-1:0]      best_port_reg, best_port_next;
    res_t                   res_reg, res_next;

    logic [TIME_BITS-1:0]   cand_release;
    logic [SEQ_W-1:0]       cand_seq;
    logic [SEQ_W-1:0]       cand_age;
    logic                   cand_ready;
    logic                   cand_before;
    logic                   hit;
    logic                   scan_done;
    logic                   full;
    logic [ADDR_W-1:0]      free_idx;
    logic [CNT_W-1:0]       occ_left;

    assign cand_release = ram_rdata[OFS_REL +: TIME_BITS];
    assign cand_seq     = ram_rdata[OFS_SEQ +: SEQ_W];

    dprq_cmp u_cmp (
        .cand_release (cand_release),
        .cand_seq     (cand_seq),
        .best_release (best_release_reg),
        .best_age     (best_age_reg),
        .now_time     (req.now),
        .seq_ctr      (seq_ctr_reg),
        .ready        (cand_ready),
        .precedes     (cand_before),
        .cand_age     (cand_age)
    );

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = ADDR_W'(i);
            end
        end
    end

    assign full = req.dup ? (occ_reg >= CNT_W'(QUEUE_DEPTH - 1))
                          : (occ_reg >= CNT_W'(QUEUE_DEPTH));
    assign hit       = rd_live_reg && valid_reg[rd_slot_reg] && cand_ready;
    assign scan_done = (scan_reg == (ADDR_W + 1)'(QUEUE_DEPTH)) && !rd_live_reg;
    assign occ_left  = occ_reg - count_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign ram_waddr = free_idx;
    assign ram_wdata = {req.release_time, seq_ctr_reg, req.port, req.ip, req.handle};

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        seq_ctr_next      = seq_ctr_reg;
        occ_next          = occ_reg;
        count_next        = count_reg;
        released_next     = released_reg;
        scan_next         = scan_reg;
        rd_live_next      = 1'b0;
        rd_slot_next      = rd_slot_reg;
        best_found_next   = best_found_reg;
        dup_left_next     = dup_left_reg;
        out_valid_next    = out_valid_reg;
        best_slot_next    = best_slot_reg;
        best_release_next = best_release_reg;
        best_age_next     = best_age_reg;
        best_handle_next  = best_handle_reg;
        best_ip_next      = best_ip_reg;
        best_port_next    = best_port_reg;
        res_next          = res_reg;
        ram_we            = 1'b0;
        ram_raddr         = scan_reg[ADDR_W-1:0];

        // scan pipeline shared by the count and search passes
        if ((state_reg == ST_COUNT || state_reg == ST_SEARCH)
            && scan_reg != (ADDR_W + 1)'(QUEUE_DEPTH))
        begin
            rd_live_next = 1'b1;
            rd_slot_next = scan_reg[ADDR_W-1:0];
            scan_next    = scan_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_next         = '0;
                res_next.last    = 1'b1;
                res_next.pending = PEND_W'(occ_reg);
                res_next.kind    = KIND_NOTHING;
                state_next       = ST_EMIT;
                out_valid_next   = 1'b1;
                dup_left_next    = 1'b0;
                unique case (req.cmd)
                    CMD_SUBMIT:
                    begin
                        if (req.drop)
                        begin
                            res_next.kind = KIND_DROPPED;
                        end
                        else if (req.zero_delay)
                        begin
                            res_next.kind   = KIND_SEND;
                            res_next.handle = req.handle;
                            res_next.ip     = req.ip;
                            res_next.port   = req.port;
                            res_next.last   = !req.dup;
                            dup_left_next   = req.dup;
                        end
                        else if (full)
                        begin
                            res_next.kind = KIND_REJECT;
                        end
                        else
                        begin
                            dup_left_next  = req.dup;
                            out_valid_next = 1'b0;
                            state_next     = ST_INSERT;
                        end
                    end
                    CMD_TICK:
                    begin
                        out_valid_next = 1'b0;
                        scan_next      = '0;
                        count_next     = '0;
                        released_next  = '0;
                        state_next     = ST_COUNT;
                    end
                    CMD_CLEAR:
                    begin
                        valid_next       = '0;
                        occ_next         = '0;
                        seq_ctr_next     = '0;
                        res_next.pending = '0;
                    end
                    default:
                    begin
                        res_next.kind = KIND_NOTHING;
                    end
                endcase
            end
            ST_INSERT:
            begin
                ram_we               = 1'b1;
                valid_next[free_idx] = 1'b1;
                seq_ctr_next         = seq_ctr_reg + 1'b1;
                occ_next             = occ_reg + 1'b1;
                if (dup_left_reg)
                begin
                    dup_left_next = 1'b0;
                end
                else
                begin
                    res_next.kind    = KIND_QUEUED;
                    res_next.pending = PEND_W'(occ_reg + 1'b1);
                    out_valid_next   = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_COUNT:
            begin
                if (hit)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (scan_done)
                begin
                    res_next = '0;
                    if (count_reg == '0)
                    begin
                        res_next.kind    = KIND_NOTHING;
                        res_next.last    = 1'b1;
                        res_next.pending = PEND_W'(occ_reg);
                        out_valid_next   = 1'b1;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        // everything counted leaves in this tick
                        occ_next        = occ_left;
                        res_next.pending = PEND_W'(occ_left);
                        released_next   = '0;
                        scan_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit && (!best_found_reg || cand_before))
                begin
                    best_found_next   = 1'b1;
                    best_slot_next    = rd_slot_reg;
                    best_release_next = cand_release;
                    best_age_next     = cand_age;
                    best_handle_next  = ram_rdata[OFS_HANDLE +: HANDLE_W];
                    best_ip_next      = ram_rdata[OFS_IP +: IP_W];
                    best_port_next    = ram_rdata[OFS_PORT +: PORT_W];
                end
                if (scan_done)
                begin
                    valid_next[best_slot_reg] = 1'b0;
                    released_next   = released_reg + 1'b1;
                    res_next.kind   = KIND_SEND;
                    res_next.handle = best_handle_reg;
                    res_next.ip     = best_ip_reg;
                    res_next.port   = best_port_reg;
                    res_next.last   = ((released_reg + 1'b1) == count_reg);
                    out_valid_next  = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_valid_reg && out_ready)
                begin
                    if (dup_left_reg)
                    begin
                        // second copy of an undelayed duplicate
                        dup_left_next = 1'b0;
                        res_next.last = 1'b1;
                    end
                    else if (req.cmd == CMD_TICK && released_reg != count_reg)
                    begin
                        out_valid_next  = 1'b0;
                        scan_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            seq_ctr_reg    <= '0;
            occ_reg        <= '0;
            count_reg      <= '0;
            released_reg   <= '0;
            scan_reg       <= '0;
            rd_live_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            dup_left_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            seq_ctr_reg    <= seq_ctr_next;
            occ_reg        <= occ_next;
            count_reg      <= count_next;
            released_reg   <= released_next;
            scan_reg       <= scan_next;
            rd_live_reg    <= rd_live_next;
            best_found_reg <= best_found_next;
            dup_left_reg   <= dup_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg      <= rd_slot_next;
        best_slot_reg    <= best_slot_next;
        best_release_reg <= best_release_next;
        best_age_reg     <= best_age_next;
        best_handle_reg  <= best_handle_next;
        best_ip_reg      <= best_ip_next;
        best_port_reg    <= best_port_next;
        res_reg          <= res_next;
    end

endmodule

// ===== hdl/delayed_packet_release_queue.sv =====
// top level of the delayed packet release queue
//
// one request enters on the s_axis channel: tuser carries the command (submit,
// tick, clear), tdata the packet descriptor, drop/duplicate flags, delay and
// current time. results leave on m_axis: tuser is the result kind, tlast marks
// the final result of a request, tdata the packet to send and the pending count.
// s_axis_tready is high only while the block is idle; one request is worked on
// at a time and its results are presented one after another.
// submit: the first result is decoded into the output register or, when the packet
// is queued, written there after the slot writes (one slot write per copy).
// tick: a counting pass over all QUEUE_DEPTH slots, then one search pass over
// all slots per released packet, since the slot memory has a single read port
// and there is one shared key comparator.
// clear and unknown commands answer one cycle after the request is taken.
// reset empties the queue (per-slot valid bits) and zeroes the sequence counter
// at once; no clearing pass is needed.
// a result waits in the output register while m_axis_tready is low; the block
// takes no new request until the last result of the current one is taken.
module delayed_packet_release_queue
    import dprq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // packet_handle, remote_ip, remote_port, drop_request, duplicate_request,
    // delay_amount, now_time, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_handle, out_ip, out_port, pending_count, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic [HANDLE_W-1:0]  in_handle;
    logic [IP_W-1:0]      in_ip;
    logic [PORT_W-1:0]    in_port;
    logic                 in_drop;
    logic                 in_dup;
    logic [DELAY_W-1:0]   in_delay;
    logic [NOW_W-1:0]     in_now;
    logic [DELAY_W-1:0]   delay_clamped;
    logic [TIME_BITS-1:0] now_t;
    logic [SUM_W-1:0]     release_sum;
    logic [TIME_BITS-1:0] release_sat;
    logic                 start;
    req_t                 req_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    res_t                 res;

    assign in_handle = s_axis_tdata[15:0];
    assign in_ip     = s_axis_tdata[47:16];
    assign in_port   = s_axis_tdata[63:48];
    assign in_drop   = s_axis_tdata[64];
    assign in_dup    = s_axis_tdata[65];
    assign in_delay  = s_axis_tdata[97:66];
    assign in_now    = s_axis_tdata[145:98];

    // negative delays clamp to zero, release time saturates at the top
    assign delay_clamped = in_delay[DELAY_W-1] ? '0 : in_delay;
    assign now_t         = TIME_BITS'(in_now);
    assign release_sum   = SUM_W'(now_t) + SUM_W'(delay_clamped);
    assign release_sat   = (release_sum[SUM_W-1:TIME_BITS] != '0) ? '1
                           : release_sum[TIME_BITS-1:0];

    assign start = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg.cmd          <= s_axis_tuser;
            req_reg.handle       <= in_handle;
            req_reg.ip           <= in_ip;
            req_reg.port         <= in_port;
            req_reg.drop         <= in_drop;
            req_reg.dup          <= in_dup;
            req_reg.zero_delay   <= (delay_clamped == '0);
            req_reg.now          <= now_t;
            req_reg.release_time <= release_sat;
        end
    end

    dprq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dprq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req_reg),
        .in_ready  (s_axis_tready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {2'b00, res.pending, res.port, res.ip, res.handle};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ===== hdl/dprq_check.sv =====
// port level checks for the delayed packet release queue, bound to the top level
module dprq_check
    import dprq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]      m_axis_tuser,
    input logic                   m_axis_tlast
);

    // no new request while a result is still waiting
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a request");

    // every result other than a send closes its request
    a_single_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_SEND) |-> m_axis_tlast)
        else $error("non-send result without last");

    // notices carry no packet
    a_notice_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_SEND) |-> (m_axis_tdata[63:0] == '0))
        else $error("non-send result with packet fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind delayed_packet_release_queue dprq_check u_dprq_check (.*);

// ===== tb/release_queue_checker.sv =====
// checker for the delayed packet release queue: predicts and compares every result
module release_queue_checker
    import dprq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]       s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [KIND_W-1:0]      m_axis_tuser,
    input  logic                   m_axis_tlast,
    output int                     fail_count,
    output int                     outstanding
);

    localparam int MAX_RELEASE = 32;
    localparam int DUP_COPIES  = 2;

    // request tdata, highest field first
    typedef struct packed {
        logic [5:0]           fill;
        logic [NOW_W-1:0]     now;
        logic [DELAY_W-1:0]   delay;
        logic                 dup;
        logic                 drop;
        logic [PORT_W-1:0]    port;
        logic [IP_W-1:0]      ip;
        logic [HANDLE_W-1:0]  handle;
    } request_fields_t;

    logic [TIME_BITS-1:0] slot_release [QUEUE_DEPTH];
    logic [SEQ_W-1:0]     slot_seq     [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]  slot_handle  [QUEUE_DEPTH];
    logic [IP_W-1:0]      slot_ip      [QUEUE_DEPTH];
    logic [PORT_W-1:0]    slot_port    [QUEUE_DEPTH];
    logic                 slot_valid   [QUEUE_DEPTH] = '{default: 1'b0};
    logic [SEQ_W-1:0]     seq_counter = '0;
    int                   occupancy = 0;
    res_t                 awaited_results[$];
    int                   failures = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        failures++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", what, got, want));
    endtask

    // equal release times go by age of the sequence number, so order survives wraparound
    function automatic bit releases_first(input int a, input int b);
        logic [SEQ_W-1:0] age_a;
        logic [SEQ_W-1:0] age_b;
        if (slot_release[a] != slot_release[b])
            return slot_release[a] < slot_release[b];
        age_a = seq_counter - slot_seq[a];
        age_b = seq_counter - slot_seq[b];
        return age_a > age_b;
    endfunction

    task automatic predict_response(input logic [CMD_W-1:0] cmd, input request_fields_t f);
        res_t                 step_out[$];
        res_t                 r;
        logic [TIME_BITS:0]   due;
        logic [DELAY_W-1:0]   delay;
        int                   copies;
        int                   placed;
        int                   best;
        r = '0;
        case (cmd)
            CMD_SUBMIT:
            begin
                copies = f.dup ? DUP_COPIES : 1;
                delay  = f.delay[DELAY_W-1] ? '0 : f.delay;
                if (f.drop)
                begin
                    r.kind = KIND_DROPPED;
                    r.last = 1'b1;
                    step_out = {step_out, r};
                end
                else if (delay == '0)
                begin
                    for (int c = 0; c < copies; c++)
                    begin
                        r.kind   = KIND_SEND;
                        r.handle = f.handle;
                        r.ip     = f.ip;
                        r.port   = f.port;
                        r.last   = (c == copies - 1);
                        step_out = {step_out, r};
                    end
                end
                else if (QUEUE_DEPTH - occupancy < copies)
                begin
                    r.kind = KIND_REJECT;
                    r.last = 1'b1;
                    step_out = {step_out, r};
                end
                else
                begin
                    due = {1'b0, f.now[TIME_BITS-1:0]} + delay;
                    // saturate at the largest time value
                    if (due[TIME_BITS])
                        due = {1'b0, {TIME_BITS{1'b1}}};
                    placed = 0;
                    for (int i = 0; i < QUEUE_DEPTH && placed < copies; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            slot_valid[i]   = 1'b1;
                            slot_release[i] = due[TIME_BITS-1:0];
                            slot_seq[i]     = seq_counter;
                            slot_handle[i]  = f.handle;
                            slot_ip[i]      = f.ip;
                            slot_port[i]    = f.port;
                            seq_counter++;
                            occupancy++;
                            placed++;
                        end
                    end
                    r.kind = KIND_QUEUED;
                    r.last = 1'b1;
                    step_out = {step_out, r};
                end
            end
            CMD_TICK:
            begin
                do
                begin
                    best = -1;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (slot_valid[i] && slot_release[i] <= f.now[TIME_BITS-1:0])
                        begin
                            if (best < 0 || releases_first(i, best))
                                best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        r.kind   = KIND_SEND;
                        r.handle = slot_handle[best];
                        r.ip     = slot_ip[best];
                        r.port   = slot_port[best];
                        r.last   = 1'b0;
                        step_out = {step_out, r};
                        slot_valid[best] = 1'b0;
                        occupancy--;
                    end
                end
                while (best >= 0 && step_out.size() < MAX_RELEASE);
                if (step_out.size() == 0)
                begin
                    r.kind = KIND_NOTHING;
                    r.last = 1'b1;
                    step_out = {step_out, r};
                end
                else
                begin
                    step_out[step_out.size() - 1].last = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
                occupancy   = 0;
                seq_counter = '0;
                r.kind = KIND_NOTHING;
                r.last = 1'b1;
                step_out = {step_out, r};
            end
            default:
            begin
                r.kind = KIND_NOTHING;
                r.last = 1'b1;
                step_out = {step_out, r};
            end
        endcase
        foreach (step_out[k])
        begin
            step_out[k].pending = PEND_W'(occupancy);
            awaited_results = {awaited_results, step_out[k]};
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result kind %0d tdata %0h",
                                              m_axis_tuser, m_axis_tdata));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", 64'(m_axis_tuser), 64'(want.kind));
                    check_field("handle", 64'(m_axis_tdata[15:0]), 64'(want.handle));
                    check_field("ip", 64'(m_axis_tdata[47:16]), 64'(want.ip));
                    check_field("port", 64'(m_axis_tdata[63:48]), 64'(want.port));
                    check_field("pending", 64'(m_axis_tdata[69:64]), 64'(want.pending));
                    check_field("fill", 64'(m_axis_tdata[71:70]), '0);
                    check_field("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_response(s_axis_tuser, s_axis_tdata);
        end
        fail_count  <= failures;
        outstanding <= awaited_results.size();
    end

endmodule

// ===== tb/delayed_packet_release_queue_tb.sv =====
// testbench top for the delayed packet release queue: stimulus, idling and verdict
module delayed_packet_release_queue_tb
    import dprq_pkg::*;
();

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0] TIME_MAX   = {NOW_W{1'b1}};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = CMD_SUBMIT;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    int               idle_send = 16;
    int               idle_recv = 59;
    int               fail_count;
    int               outstanding;
    logic [NOW_W-1:0] sim_now = 48'd1000;

    delayed_packet_release_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    release_queue_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= idle_recv);

    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
                                 input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                                 input logic drop, input logic dup,
                                 input logic [DELAY_W-1:0] delay, input logic [NOW_W-1:0] now);
        @(negedge clk);
        while ($urandom_range(99) < idle_send)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, now, delay, dup, drop, port, ip, handle};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic random_request();
        logic [CMD_W-1:0]   cmd;
        logic [DELAY_W-1:0] delay;
        logic [NOW_W-1:0]   now;
        int                 pick;
        int                 delay_pick;
        pick       = $urandom_range(99);
        delay_pick = $urandom_range(19);
        now        = sim_now;
        case (delay_pick)
            0: delay = '0;
            1: delay = $urandom | 32'h8000_0000;
            2: delay = $urandom;
            3: delay = 32'h7FFF_FFFF;
            default: delay = $urandom_range(40, 1);
        endcase
        if (pick < 55)
        begin
            cmd = CMD_SUBMIT;
            // a far-off time now and then parks entries until a full release or a clear
            if ($urandom_range(19) == 0)
                now = NOW_W'({$urandom, $urandom});
        end
        else if (pick < 85)
        begin
            cmd     = CMD_TICK;
            sim_now = sim_now + $urandom_range(15);
            now     = ($urandom_range(14) == 0) ? TIME_MAX : sim_now;
        end
        else if (pick < 93)
        begin
            cmd = CMD_CLEAR;
        end
        else
        begin
            cmd = CMD_UNUSED;
            now = NOW_W'({$urandom, $urandom});
        end
        issue_request(cmd, HANDLE_W'($urandom), $urandom, PORT_W'($urandom),
                      $urandom_range(9) == 0, $urandom_range(2) == 0, delay, now);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue_request(CMD_TICK, 16'h1234, 32'h0, 16'h0, 1'b0, 1'b0, 32'd0, 48'd50);
        issue_request(CMD_SUBMIT, 16'h0000, 32'h0, 16'h0000, 1'b0, 1'b0, 32'd0, 48'd0);
        issue_request(CMD_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 32'd0, TIME_MAX);
        issue_request(CMD_SUBMIT, 16'hA5A5, 32'hC0A8_0001, 16'd53, 1'b0, 1'b0,
                      32'h8000_0000, 48'd10);
        issue_request(CMD_SUBMIT, 16'h5A5A, 32'h0A00_0001, 16'd80, 1'b1, 1'b1, 32'd5, 48'd10);
        // two copies with one release time, then a saturated release time
        issue_request(CMD_SUBMIT, 16'h0101, 32'h0101_0101, 16'd1001, 1'b0, 1'b1, 32'd1, 48'd100);
        issue_request(CMD_SUBMIT, 16'h0202, 32'h0202_0202, 16'd1002, 1'b0, 1'b0,
                      32'h7FFF_FFFF, TIME_MAX);
        issue_request(CMD_TICK, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 32'd0, 48'd100);
        issue_request(CMD_TICK, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 32'd0, 48'd101);
        issue_request(CMD_UNUSED, 16'hBEEF, 32'hDEAD_BEEF, 16'hCAFE, 1'b1, 1'b1, 32'd9, 48'd7);
        // fill the queue up to one free slot
        repeat (15)
            issue_request(CMD_SUBMIT, HANDLE_W'($urandom), $urandom, PORT_W'($urandom),
                          1'b0, 1'b1, $urandom_range(50, 1), 48'd200);
        issue_request(CMD_SUBMIT, 16'h0303, 32'h0303_0303, 16'd3, 1'b0, 1'b1, 32'd3, 48'd200);
        issue_request(CMD_SUBMIT, 16'h0404, 32'h0404_0404, 16'd4, 1'b0, 1'b0, 32'd3, 48'd200);
        issue_request(CMD_SUBMIT, 16'h0505, 32'h0505_0505, 16'd5, 1'b0, 1'b0, 32'd3, 48'd200);
        issue_request(CMD_TICK, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 32'd0, TIME_MAX);
        issue_request(CMD_CLEAR, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 32'd0, 48'd0);

        repeat (50)
            random_request();
        idle_send = 59;
        idle_recv = 16;
        repeat (50)
            random_request();
        idle_send = 0;
        idle_recv = 0;
        repeat (50)
            random_request();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dprq_pkg.sv
hdl/dprq_ram.sv
hdl/dprq_cmp.sv
hdl/dprq_seq.sv
hdl/delayed_packet_release_queue.sv
hdl/dprq_check.sv
tb/release_queue_checker.sv
tb/delayed_packet_release_queue_tb.sv
